// ===== rtl/vna_pkg.sv =====
// shared types and constants of the vertex normal accumulator
// no dependencies; imported by every module of the block
package vna_pkg;

  localparam int unsigned VERTEX_COUNT_DEF = 1024;
  localparam int unsigned SUM_BITS_DEF     = 48;

  localparam int unsigned IDX_W   = 10;  // vertex index
  localparam int unsigned POS_W   = 16;  // Q7.8 coordinate
  localparam int unsigned NRM_W   = 16;  // Q1.14 normal component
  localparam int unsigned DIF_W   = 17;  // edge vector component
  localparam int unsigned CR_W    = 35;  // exact cross product component
  localparam int unsigned MUL_W   = 32;  // shared multiplier operand
  localparam int unsigned ACC_W   = 64;  // multiply-accumulate register
  localparam int unsigned T_W     = 30;  // normalized magnitude
  localparam int unsigned ROOT_W  = 31;  // root of the squared length
  localparam int unsigned QUO_W   = 15;  // quotient, at most 16384
  localparam int unsigned FRAC_SH = 14;  // Q1.14 scale
  localparam int unsigned NUM_W   = 45;  // t * 2^14 + r / 2
  localparam int unsigned CNT_W   = 3;   // sequencer step counter

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_TRIANGLE = 2'd1,
    CMD_QUERY    = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRI_RD,
    ST_TRI_MUL,
    ST_TRI_ACC,
    ST_Q_RD,
    ST_Q_CHK,
    ST_Q_NORM,
    ST_Q_SQ,
    ST_Q_ROOT,
    ST_Q_DIV,
    ST_Q_OUT
  } state_e;

  typedef enum logic {
    RD_ROOT,
    RD_DIV
  } rd_op_e;

  typedef struct packed {
    logic   start;
    rd_op_e op;
  } rd_ctl_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
  } mac_ctl_t;

endpackage

// ===== rtl/vna_mac.sv =====
// shared signed multiply-accumulate unit, one product per cycle
// depends on vna_pkg
module vna_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vna_pkg::mac_ctl_t                 ctl_i,
  input  logic signed [vna_pkg::MUL_W-1:0]  a_i,
  input  logic signed [vna_pkg::MUL_W-1:0]  b_i,
  output logic signed [vna_pkg::ACC_W-1:0]  acc_o
);
  import vna_pkg::*;

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] acc_d, acc_q;

  always_comb begin
    prod  = ACC_W'(a_i) * ACC_W'(b_i);
    base  = ctl_i.clr ? '0 : acc_q;
    acc_d = ctl_i.sub ? base - prod : base + prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/vna_rootdiv.sv =====
// iterative integer square root (two radicand bits a cycle) and
// restoring divider (one quotient bit a cycle); depends on vna_pkg
module vna_rootdiv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vna_pkg::rd_ctl_t            ctl_i,
  input  logic [vna_pkg::ACC_W-1:0]   radicand_i,
  input  logic [vna_pkg::NUM_W-1:0]   num_i,
  input  logic [vna_pkg::ROOT_W-1:0]  den_i,
  output logic                        busy_o,
  output logic [vna_pkg::ROOT_W-1:0]  result_o
);
  import vna_pkg::*;

  localparam logic [ACC_W-1:0] BIT_START = ACC_W'(1) << (ACC_W - 2);

  logic             busy_q;
  rd_op_e           op_q;
  logic [CNT_W:0]   cnt_q;
  logic [ACC_W-1:0] x_q, res_q, bit_q;
  logic [ROOT_W-1:0] rem_q, den_q;
  logic [QUO_W-1:0] num_q, quo_q;

  logic [ACC_W-1:0] trial;
  logic             take_root;
  logic [ROOT_W:0]  rem2;
  logic             take_div;

  always_comb begin
    trial     = res_q + bit_q;
    take_root = x_q >= trial;
    rem2      = {rem_q, num_q[QUO_W-1]};
    take_div  = rem2 >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= RD_ROOT;
      cnt_q  <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      op_q   <= ctl_i.op;
      cnt_q  <= (CNT_W+1)'(QUO_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (op_q == RD_ROOT) begin
        // last step when the trial bit reaches the lsb
        if (bit_q[0]) busy_q <= 1'b0;
      end else begin
        if (cnt_q == '0) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      x_q   <= radicand_i;
      res_q <= '0;
      bit_q <= BIT_START;
      rem_q <= {1'b0, num_i[NUM_W-1:QUO_W]};
      num_q <= num_i[QUO_W-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      if (op_q == RD_ROOT) begin
        if (take_root) begin
          x_q   <= x_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end else begin
        rem_q <= take_div ? ROOT_W'(rem2 - {1'b0, den_q}) : rem2[ROOT_W-1:0];
        num_q <= num_q << 1;
        quo_q <= {quo_q[QUO_W-2:0], take_div};
      end
    end
  end

  assign busy_o   = busy_q;
  assign result_o = (op_q == RD_ROOT) ? res_q[ROOT_W-1:0] : ROOT_W'(quo_q);

endmodule

// ===== rtl/vertex_normal_accumulator.sv =====
// area-weighted vertex normal accumulator: position and sum memories,
// command sequencer; depends on vna_pkg, vna_mac and vna_rootdiv
//
// Input channel (in_valid_i / in_stall_o) takes one command per transfer:
// write vertex, add triangle or query normal. in_stall_o is high while a
// command is being worked on. Only a query gives a result on the output
// channel (out_valid_o / out_stall_i), held in an output register so the
// next command is taken while the result waits.
// Work per command:
//   write vertex: both memories written at the transfer
//   add triangle: 3 position reads, 6 products on the shared
//                 multiplier, 3 read-modify-writes of the sum memory
//   query: up to 29 one-bit normalizing shifts (with the default
//          SUM_BITS), then 32 root steps and 3 x 15 divide steps in
//          the shared root/divide unit
// A query finishing while the previous result is still stalled waits in
// its last step until the output register frees.
// Reset clears the sequencer and output valid; memory is undefined until
// written; the user writes every vertex before it is used (unchecked).
module vertex_normal_accumulator #(
  parameter int unsigned VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF,
  parameter int unsigned SUM_BITS     = vna_pkg::SUM_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         command_i,
  input  logic [vna_pkg::IDX_W-1:0]          vertex_index_i,
  input  logic signed [vna_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [vna_pkg::POS_W-1:0]   pos_y_i,
  input  logic signed [vna_pkg::POS_W-1:0]   pos_z_i,
  input  logic [vna_pkg::IDX_W-1:0]          corner_a_i,
  input  logic [vna_pkg::IDX_W-1:0]          corner_b_i,
  input  logic [vna_pkg::IDX_W-1:0]          corner_c_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [vna_pkg::NRM_W-1:0]   normal_x_o,
  output logic signed [vna_pkg::NRM_W-1:0]   normal_y_o,
  output logic signed [vna_pkg::NRM_W-1:0]   normal_z_o,
  output logic                               degenerate_o
);
  import vna_pkg::*;

  localparam int unsigned AW    = $clog2(VERTEX_COUNT);
  localparam int unsigned ROW_W = 3 * SUM_BITS;

  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_W+AW-1:0] w;
    w = {{AW{1'b0}}, idx};
    return w[AW-1:0];
  endfunction

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < VERTEX_COUNT;
  endfunction

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] s,
                                                  input logic signed [CR_W-1:0] d);
    logic signed [SUM_BITS:0] e;
    e = $signed({s[SUM_BITS-1], s}) + (SUM_BITS+1)'(d);
    if (e[SUM_BITS] != e[SUM_BITS-1]) begin
      return e[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end
    return e[SUM_BITS-1:0];
  endfunction

  // memories
  logic [3*POS_W-1:0] pos_mem [VERTEX_COUNT];
  logic [ROW_W-1:0]   sum_mem [VERTEX_COUNT];

  logic               pos_we, pos_re;
  logic [AW-1:0]      pos_wa, pos_ra;
  logic [3*POS_W-1:0] pos_wd, pos_rd_q;
  logic               sum_we, sum_re;
  logic [AW-1:0]      sum_wa, sum_ra;
  logic [ROW_W-1:0]   sum_wd, sum_rd_q;

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (pos_re) pos_rd_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    if (sum_re) sum_rd_q <= sum_mem[sum_ra];
  end

  // control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       comp_q, comp_d;
  logic             started_q, started_d;
  logic             out_valid_q, out_valid_d;
  logic             out_load;

  // payload
  logic [IDX_W-1:0]        corner_q [3];
  logic [IDX_W-1:0]        qidx_q;
  logic                    rd_ok_q;
  logic signed [POS_W-1:0] pa_q [3];
  logic signed [POS_W-1:0] pb_q [3];
  logic signed [DIF_W-1:0] u_q [3];
  logic signed [DIF_W-1:0] v_q [3];
  logic signed [CR_W-1:0]  cr_q [3];
  logic [SUM_BITS-1:0]     t_q [3];
  logic [2:0]              neg_q;
  logic [ROOT_W-1:0]       r_q;
  logic signed [NRM_W-1:0] nrm_q [3];
  logic                    degen_q;
  logic signed [NRM_W-1:0] out_x_q, out_y_q, out_z_q;
  logic                    out_degen_q;

  logic                    accept;
  logic signed [POS_W-1:0] pc [3];
  logic [SUM_BITS-1:0]     s [3];
  logic                    s_zero;
  logic [SUM_BITS-1:0]     or_t;
  logic [1:0]              k;
  logic [IDX_W-1:0]        corner_sel;
  logic [SUM_BITS-1:0]     t_sel;
  logic [QUO_W-1:0]        quo;

  mac_ctl_t                mac_ctl;
  logic signed [MUL_W-1:0] mac_a, mac_b;
  logic signed [ACC_W-1:0] mac_acc;
  rd_ctl_t                 rd_ctl;
  logic [NUM_W-1:0]        rd_num;
  logic                    rd_busy;
  logic [ROOT_W-1:0]       rd_result;

  vna_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (mac_acc)
  );

  vna_rootdiv u_rootdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (rd_ctl),
    .radicand_i ($unsigned(mac_acc)),
    .num_i      (rd_num),
    .den_i      (r_q),
    .busy_o     (rd_busy),
    .result_o   (rd_result)
  );

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pc[j] = rd_ok_q ? $signed(pos_rd_q[j*POS_W +: POS_W]) : '0;
      s[j]  = rd_ok_q ? sum_rd_q[j*SUM_BITS +: SUM_BITS] : '0;
    end
    s_zero     = (s[0] == '0) && (s[1] == '0) && (s[2] == '0);
    or_t       = t_q[0] | t_q[1] | t_q[2];
    k          = (state_q == ST_TRI_ACC) ? cnt_q[2:1] : cnt_q[1:0];
    corner_sel = corner_q[k];
    t_sel      = t_q[comp_q];
    rd_num     = NUM_W'({t_sel[T_W-1:0], {FRAC_SH{1'b0}}}) + NUM_W'(r_q >> 1);
    quo        = rd_result[QUO_W-1:0];
  end

  // sequencer: next state, memory ports and unit controls
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    comp_d      = comp_q;
    started_d   = started_q;
    out_load    = 1'b0;
    pos_we      = 1'b0;
    pos_wa      = to_addr(vertex_index_i);
    pos_wd      = {pos_z_i, pos_y_i, pos_x_i};
    pos_re      = 1'b0;
    pos_ra      = to_addr(corner_sel);
    sum_we      = 1'b0;
    sum_wa      = to_addr(vertex_index_i);
    sum_wd      = '0;
    sum_re      = 1'b0;
    sum_ra      = to_addr(corner_sel);
    mac_ctl     = '0;
    mac_a       = '0;
    mac_b       = '0;
    rd_ctl      = '{start: 1'b0, op: RD_ROOT};

    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          case (command_i)
            CMD_WRITE: begin
              pos_we = in_range(vertex_index_i);
              sum_we = in_range(vertex_index_i);
            end
            CMD_TRIANGLE: state_d = ST_TRI_RD;
            CMD_QUERY:    state_d = ST_Q_RD;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_TRI_RD: begin
        pos_re = (cnt_q < CNT_W'(3));
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(3)) begin
          cnt_d   = '0;
          state_d = ST_TRI_MUL;
        end
      end
      ST_TRI_MUL: begin
        mac_ctl.en = 1'b1;
        case (cnt_q)
          CNT_W'(0): begin
            mac_ctl.clr = 1'b1; mac_a = MUL_W'(u_q[1]); mac_b = MUL_W'(v_q[2]);
          end
          CNT_W'(1): begin
            mac_ctl.sub = 1'b1; mac_a = MUL_W'(u_q[2]); mac_b = MUL_W'(v_q[1]);
          end
          CNT_W'(2): begin
            mac_ctl.clr = 1'b1; mac_a = MUL_W'(u_q[2]); mac_b = MUL_W'(v_q[0]);
          end
          CNT_W'(3): begin
            mac_ctl.sub = 1'b1; mac_a = MUL_W'(u_q[0]); mac_b = MUL_W'(v_q[2]);
          end
          CNT_W'(4): begin
            mac_ctl.clr = 1'b1; mac_a = MUL_W'(u_q[0]); mac_b = MUL_W'(v_q[1]);
          end
          CNT_W'(5): begin
            mac_ctl.sub = 1'b1; mac_a = MUL_W'(u_q[1]); mac_b = MUL_W'(v_q[0]);
          end
          default: mac_ctl.en = 1'b0;
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(6)) begin
          cnt_d   = '0;
          state_d = ST_TRI_ACC;
        end
      end
      ST_TRI_ACC: begin
        // even step reads a corner's sums, odd step writes them back
        sum_re = ~cnt_q[0];
        sum_wa = to_addr(corner_sel);
        sum_we = cnt_q[0] & in_range(corner_sel);
        for (int j = 0; j < 3; j++) begin
          sum_wd[j*SUM_BITS +: SUM_BITS] =
            sat_add(sum_rd_q[j*SUM_BITS +: SUM_BITS], cr_q[j]);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(5)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_Q_RD: begin
        sum_re  = 1'b1;
        sum_ra  = to_addr(qidx_q);
        state_d = ST_Q_CHK;
      end
      ST_Q_CHK: begin
        state_d = s_zero ? ST_Q_OUT : ST_Q_NORM;
      end
      ST_Q_NORM: begin
        if (~(|or_t[SUM_BITS-1:T_W]) && or_t[T_W-1]) begin
          cnt_d   = '0;
          state_d = ST_Q_SQ;
        end
      end
      ST_Q_SQ: begin
        mac_ctl.en  = (cnt_q != CNT_W'(3));
        mac_ctl.clr = (cnt_q == CNT_W'(0));
        mac_a       = MUL_W'(t_q[cnt_q[1:0]][T_W-1:0]);
        mac_b       = MUL_W'(t_q[cnt_q[1:0]][T_W-1:0]);
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(3)) begin
          rd_ctl  = '{start: 1'b1, op: RD_ROOT};
          cnt_d   = '0;
          state_d = ST_Q_ROOT;
        end
      end
      ST_Q_ROOT: begin
        if (!rd_busy) begin
          comp_d    = '0;
          started_d = 1'b0;
          state_d   = ST_Q_DIV;
        end
      end
      ST_Q_DIV: begin
        if (!started_q) begin
          rd_ctl    = '{start: 1'b1, op: RD_DIV};
          started_d = 1'b1;
        end else if (!rd_busy) begin
          started_d = 1'b0;
          comp_d    = comp_q + 1'b1;
          if (comp_q == 2'd2) state_d = ST_Q_OUT;
        end
      end
      ST_Q_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = (out_valid_q & out_stall_i) | out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      comp_q      <= comp_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      corner_q[0] <= corner_a_i;
      corner_q[1] <= corner_b_i;
      corner_q[2] <= corner_c_i;
      qidx_q      <= vertex_index_i;
    end
    if (pos_re) rd_ok_q <= in_range(corner_sel);
    if (state_q == ST_Q_RD) rd_ok_q <= in_range(qidx_q);

    if (state_q == ST_TRI_RD) begin
      for (int j = 0; j < 3; j++) begin
        if (cnt_q == CNT_W'(1)) pa_q[j] <= pc[j];
        if (cnt_q == CNT_W'(2)) pb_q[j] <= pc[j];
        if (cnt_q == CNT_W'(3)) begin
          u_q[j] <= DIF_W'(pc[j]) - DIF_W'(pb_q[j]);
          v_q[j] <= DIF_W'(pa_q[j]) - DIF_W'(pb_q[j]);
        end
      end
    end

    if (state_q == ST_TRI_MUL) begin
      if (cnt_q == CNT_W'(2)) cr_q[0] <= CR_W'(mac_acc);
      if (cnt_q == CNT_W'(4)) cr_q[1] <= CR_W'(mac_acc);
      if (cnt_q == CNT_W'(6)) cr_q[2] <= CR_W'(mac_acc);
    end

    if (state_q == ST_Q_CHK) begin
      degen_q <= s_zero;
      for (int j = 0; j < 3; j++) begin
        neg_q[j] <= s[j][SUM_BITS-1];
        t_q[j]   <= s[j][SUM_BITS-1] ? (~s[j] + 1'b1) : s[j];
        nrm_q[j] <= '0;
      end
    end

    if (state_q == ST_Q_NORM) begin
      // bring the largest magnitude into [2^29, 2^30)
      for (int j = 0; j < 3; j++) begin
        if (|or_t[SUM_BITS-1:T_W]) t_q[j] <= t_q[j] >> 1;
        else if (!or_t[T_W-1]) t_q[j] <= t_q[j] << 1;
      end
    end

    if (state_q == ST_Q_ROOT && !rd_busy) r_q <= rd_result;

    if (state_q == ST_Q_DIV && started_q && !rd_busy) begin
      nrm_q[comp_q] <= neg_q[comp_q] ? -$signed(NRM_W'(quo)) : $signed(NRM_W'(quo));
    end

    if (out_load) begin
      out_x_q     <= nrm_q[0];
      out_y_q     <= nrm_q[1];
      out_z_q     <= nrm_q[2];
      out_degen_q <= degen_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = out_x_q;
  assign normal_y_o   = out_y_q;
  assign normal_z_o   = out_z_q;
  assign degenerate_o = out_degen_q;

endmodule
